>>> rtl/core/rcbc_pkg.sv
// ----------------------------------------------------------------------------
// rcbc_pkg
// Shared constants, register indexes and pixel conversion functions for the
// RGB565 centered blit converter.
// ----------------------------------------------------------------------------
package rcbc_pkg;

	localparam int MAX_DIM   = 2048;
	localparam int DIM_W     = 12;
	localparam int CNT_W     = 11;
	localparam int STRIDE_W  = 14;
	localparam int LAYOUT_W  = 27;
	localparam int GROUP_W   = 9;
	localparam int ADDR_W    = 24;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 27;

	localparam logic [DIM_W-1:0]    DIM_RESET    = 12'd240;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd480;
	localparam logic [LAYOUT_W-1:0] LAYOUT_RESET = 27'd42044075;
	localparam logic [DIM_W-1:0]    DIM_MAX      = DIM_W'(MAX_DIM);

	// layout groups that select the unmodified 565 format
	localparam logic [GROUP_W-1:0] GROUP_565_RED   = {4'd5, 5'd11};
	localparam logic [GROUP_W-1:0] GROUP_565_GREEN = {4'd6, 5'd5};
	localparam logic [GROUP_W-1:0] GROUP_565_BLUE  = {4'd5, 5'd0};

	// floor(c*255/31) = (c*255*33826) >> 20 for c in 0..31
	localparam logic [28:0] EXP5_MUL = 29'(255 * 33826);
	// floor(c*255/63) = (c*255*66577) >> 22 for c in 0..63
	localparam logic [30:0] EXP6_MUL = 31'(255 * 66577);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH    = 3'd0,
		CFG_FRAME_HEIGHT   = 3'd1,
		CFG_SCREEN_WIDTH   = 3'd2,
		CFG_SCREEN_HEIGHT  = 3'd3,
		CFG_LINE_STRIDE    = 3'd4,
		CFG_PIXEL_MODE     = 3'd5,
		CFG_CHANNEL_LAYOUT = 3'd6
	} cfg_index_t;

	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [28:0] p;
		p = 29'(c) * EXP5_MUL;
		return p[27:20];
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [30:0] p;
		p = 31'(c) * EXP6_MUL;
		return p[29:22];
	endfunction

	// group: [4:0] bit offset, [8:5] length (0 = absent, above 8 = 8)
	function automatic logic [DATA_W-1:0] place_channel(input logic [7:0] value8,
			input logic [GROUP_W-1:0] group);
		logic [4:0]        off;
		logic [3:0]        len;
		logic [3:0]        sh;
		logic [7:0]        v;
		logic [DATA_W-1:0] w;
		off = group[4:0];
		len = (group[8:5] > 4'd8) ? 4'd8 : group[8:5];
		sh  = 4'd8 - len;
		v   = value8 >> sh;
		w   = {24'd0, v} << off;
		return (group[8:5] == 4'd0) ? '0 : w;
	endfunction

endpackage

>>> rtl/core/rgb565_centered_blit_converter_core.sv
// ----------------------------------------------------------------------------
// rgb565_centered_blit_converter_core
// Converts a raster stream of RGB565 pixels into screen buffer writes,
// centered on the screen, with optional channel repacking.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input word passes the input register, then the result register.
// Throughput: one word per cycle; with the result stalled the input register
// still takes one more word, then in_stall rises until the result moves.
// Reset: arst_n clears the pipeline valids, the column and row counts and
// loads the configuration registers with their default values.
module rgb565_centered_blit_converter_core
	import rcbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          src_pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ADDR_W-1:0]    write_address,
	output logic [DATA_W-1:0]    write_data,
	output logic                 write_wide,
	output logic                 frame_last
);

	logic [DIM_W-1:0]    frame_width_q;
	logic [DIM_W-1:0]    frame_height_q;
	logic [DIM_W-1:0]    screen_width_q;
	logic [DIM_W-1:0]    screen_height_q;
	logic [STRIDE_W-1:0] line_stride_q;
	logic                pixel_mode_q;
	logic [LAYOUT_W-1:0] channel_layout_q;

	logic [CNT_W-1:0] column_count_q;
	logic [CNT_W-1:0] row_count_q;

	logic             valid_s1;
	logic [15:0]      pix_s1;
	logic [DIM_W-1:0] xpos_s1;
	logic [DIM_W-1:0] ypos_s1;
	logic             last_s1;

	logic              out_valid_q;
	logic [ADDR_W-1:0] write_address_q;
	logic [DATA_W-1:0] write_data_q;
	logic              write_wide_q;
	logic              frame_last_q;

	logic             out_adv;
	logic             in_acc;
	logic [DIM_W-1:0] fw;
	logic [DIM_W-1:0] fh;
	logic [DIM_W-1:0] xoff;
	logic [DIM_W-1:0] yoff;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             last_col;
	logic             last_row;

	logic [GROUP_W-1:0]  red_g;
	logic [GROUP_W-1:0]  green_g;
	logic [GROUP_W-1:0]  blue_g;
	logic                passthrough;
	logic [DATA_W-1:0]   packed_word;
	logic [DATA_W-1:0]   data_c;
	logic [25:0]         row_bytes;
	logic [13:0]         col_bytes;
	logic [ADDR_W-1:0]   addr_c;

	// handshake
	assign out_adv  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_adv;
	assign in_acc   = in_valid && !in_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= DIM_RESET;
			frame_height_q   <= DIM_RESET;
			screen_width_q   <= DIM_RESET;
			screen_height_q  <= DIM_RESET;
			line_stride_q    <= STRIDE_RESET;
			pixel_mode_q     <= 1'b0;
			channel_layout_q <= LAYOUT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:    frame_width_q    <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[DIM_W-1:0];
				CFG_SCREEN_WIDTH:   screen_width_q   <= cfg_data[DIM_W-1:0];
				CFG_SCREEN_HEIGHT:  screen_height_q  <= cfg_data[DIM_W-1:0];
				CFG_LINE_STRIDE:    line_stride_q    <= cfg_data[STRIDE_W-1:0];
				CFG_PIXEL_MODE:     pixel_mode_q     <= cfg_data[0];
				CFG_CHANNEL_LAYOUT: channel_layout_q <= cfg_data[LAYOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// position and centering
	always_comb begin
		fw = (frame_width_q == '0) ? DIM_W'(1) :
			(frame_width_q > DIM_MAX) ? DIM_MAX : frame_width_q;
		fh = (frame_height_q == '0) ? DIM_W'(1) :
			(frame_height_q > DIM_MAX) ? DIM_MAX : frame_height_q;
		xoff = (screen_width_q > fw) ? DIM_W'((screen_width_q - fw) >> 1) : '0;
		yoff = (screen_height_q > fh) ? DIM_W'((screen_height_q - fh) >> 1) : '0;
		col_inc  = {1'b0, column_count_q} + DIM_W'(1);
		row_inc  = {1'b0, row_count_q} + DIM_W'(1);
		last_col = col_inc >= fw;
		last_row = row_inc >= fh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				column_count_q <= '0;
				row_count_q    <= last_row ? '0 : row_inc[CNT_W-1:0];
			end else begin
				column_count_q <= col_inc[CNT_W-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= src_pixel;
			xpos_s1 <= {1'b0, column_count_q} + xoff;
			ypos_s1 <= {1'b0, row_count_q} + yoff;
			last_s1 <= last_col && last_row;
		end
	end

	// pixel conversion and address
	always_comb begin
		red_g   = channel_layout_q[8:0];
		green_g = channel_layout_q[17:9];
		blue_g  = channel_layout_q[26:18];
		passthrough = !pixel_mode_q && red_g == GROUP_565_RED &&
			green_g == GROUP_565_GREEN && blue_g == GROUP_565_BLUE;
		packed_word = place_channel(expand5(pix_s1[15:11]), red_g) |
			place_channel(expand6(pix_s1[10:5]), green_g) |
			place_channel(expand5(pix_s1[4:0]), blue_g);
		if (passthrough) begin
			data_c = {16'd0, pix_s1};
		end else if (!pixel_mode_q) begin
			data_c = {16'd0, packed_word[15:0]};
		end else begin
			data_c = packed_word;
		end
		row_bytes = 26'(ypos_s1) * 26'(line_stride_q);
		col_bytes = pixel_mode_q ? {xpos_s1, 2'b00} : {1'b0, xpos_s1, 1'b0};
		addr_c    = row_bytes[ADDR_W-1:0] + ADDR_W'(col_bytes);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			write_address_q <= addr_c;
			write_data_q    <= data_c;
			write_wide_q    <= pixel_mode_q;
			frame_last_q    <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = write_address_q;
	assign write_data    = write_data_q;
	assign write_wide    = write_wide_q;
	assign frame_last    = frame_last_q;

endmodule
